[sv/qvr_pkg.sv]
// Shared constants for the quaternion vector rotation block.
package qvr_pkg;

    localparam int QUAT_WIDTH_DEF = 16;
    localparam int VEC_WIDTH_DEF  = 32;
    localparam int NUM_AXES       = 3;

endpackage

[sv/qvr_in_if.sv]
// Input channel: quaternion and body-frame vector with valid/ready.
interface qvr_in_if #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [VEC_WIDTH-1:0]  body_x;
    logic signed [VEC_WIDTH-1:0]  body_y;
    logic signed [VEC_WIDTH-1:0]  body_z;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, body_x, body_y, body_z,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, body_x, body_y, body_z,
        output ready
    );
endinterface

[sv/qvr_out_if.sv]
// Output channel: world-frame vector and saturation flag with valid/ready.
interface qvr_out_if #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] world_x;
    logic signed [VEC_WIDTH-1:0] world_y;
    logic signed [VEC_WIDTH-1:0] world_z;
    logic                        saturated;

    modport source (
        output valid, world_x, world_y, world_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, world_x, world_y, world_z, saturated,
        output ready
    );
endinterface

[sv/qvr_matrix.sv]
// Quaternion products and rotation matrix, two pipeline stages.
module qvr_matrix #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [QUAT_WIDTH-1:0]   quat_x,
    input  logic signed [QUAT_WIDTH-1:0]   quat_y,
    input  logic signed [QUAT_WIDTH-1:0]   quat_z,
    input  logic signed [QUAT_WIDTH-1:0]   quat_w,
    input  logic signed [VEC_WIDTH-1:0]    body [qvr_pkg::NUM_AXES],
    output logic signed [2*QUAT_WIDTH+1:0] mat [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES],
    output logic signed [VEC_WIDTH-1:0]    vec [qvr_pkg::NUM_AXES]
);
    localparam int PW = 2 * QUAT_WIDTH;
    localparam int MW = 2 * QUAT_WIDTH + 2;

    logic signed [PW-1:0] p00_reg, p11_reg, p22_reg, p33_reg;
    logic signed [PW-1:0] p01_reg, p02_reg, p03_reg, p12_reg, p13_reg, p23_reg;
    logic signed [VEC_WIDTH-1:0] vec_a_reg [qvr_pkg::NUM_AXES];
    logic signed [VEC_WIDTH-1:0] vec_b_reg [qvr_pkg::NUM_AXES];
    logic signed [MW-1:0] mat_reg [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES];

    // q0 = w, q1 = x, q2 = y, q3 = z
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg   <= quat_w * quat_w;
            p11_reg   <= quat_x * quat_x;
            p22_reg   <= quat_y * quat_y;
            p33_reg   <= quat_z * quat_z;
            p01_reg   <= quat_w * quat_x;
            p02_reg   <= quat_w * quat_y;
            p03_reg   <= quat_w * quat_z;
            p12_reg   <= quat_x * quat_y;
            p13_reg   <= quat_x * quat_z;
            p23_reg   <= quat_y * quat_z;
            vec_a_reg <= body;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg[0][0] <= MW'(p00_reg) + MW'(p11_reg) - MW'(p22_reg) - MW'(p33_reg);
            mat_reg[0][1] <= (MW'(p12_reg) - MW'(p03_reg)) <<< 1;
            mat_reg[0][2] <= (MW'(p02_reg) + MW'(p13_reg)) <<< 1;
            mat_reg[1][0] <= (MW'(p03_reg) + MW'(p12_reg)) <<< 1;
            mat_reg[1][1] <= MW'(p00_reg) - MW'(p11_reg) + MW'(p22_reg) - MW'(p33_reg);
            mat_reg[1][2] <= (MW'(p23_reg) - MW'(p01_reg)) <<< 1;
            mat_reg[2][0] <= (MW'(p13_reg) - MW'(p02_reg)) <<< 1;
            mat_reg[2][1] <= (MW'(p01_reg) + MW'(p23_reg)) <<< 1;
            mat_reg[2][2] <= MW'(p00_reg) - MW'(p11_reg) - MW'(p22_reg) + MW'(p33_reg);
            vec_b_reg     <= vec_a_reg;
        end
    end

    assign mat = mat_reg;
    assign vec = vec_b_reg;

endmodule

[sv/qvr_lane.sv]
// One output row: exact dot product of a matrix row with the body vector.
module qvr_lane #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic signed [2*QUAT_WIDTH+1:0]            row [qvr_pkg::NUM_AXES],
    input  logic signed [VEC_WIDTH-1:0]               vec [qvr_pkg::NUM_AXES],
    output logic signed [2*QUAT_WIDTH+VEC_WIDTH+3:0]  acc
);
    localparam int MW  = 2 * QUAT_WIDTH + 2;
    localparam int K   = (MW + 1) / 2;
    localparam int HW  = MW - K;
    localparam int LPW = K + 1 + VEC_WIDTH;
    localparam int HPW = HW + VEC_WIDTH;
    localparam int CW  = MW + VEC_WIDTH;
    localparam int AW  = CW + 2;

    logic signed [LPW-1:0] lo_prod_reg [qvr_pkg::NUM_AXES];
    logic signed [HPW-1:0] hi_prod_reg [qvr_pkg::NUM_AXES];
    logic signed [CW-1:0]  col_reg     [qvr_pkg::NUM_AXES];
    logic signed [AW-1:0]  acc_reg;

    // matrix element split into signed high half and unsigned low half
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < qvr_pkg::NUM_AXES; j++)
            begin
                lo_prod_reg[j] <= $signed({1'b0, row[j][K-1:0]}) * vec[j];
                hi_prod_reg[j] <= $signed(row[j][MW-1:K]) * vec[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < qvr_pkg::NUM_AXES; j++)
            begin
                col_reg[j] <= (CW'(hi_prod_reg[j]) <<< K) + CW'(lo_prod_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= AW'(col_reg[0]) + AW'(col_reg[1]) + AW'(col_reg[2]);
        end
    end

    assign acc = acc_reg;

endmodule

[sv/qvr_merge.sv]
// Merge stage: round, scale, saturate the lane sums and register the result.
module qvr_merge #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [2*QUAT_WIDTH+VEC_WIDTH+3:0] acc [qvr_pkg::NUM_AXES],
    output logic signed [VEC_WIDTH-1:0]              world [qvr_pkg::NUM_AXES],
    output logic                                     saturated
);
    localparam int AW = 2 * QUAT_WIDTH + VEC_WIDTH + 4;
    localparam int FS = 2 * (QUAT_WIDTH - 2);
    localparam int RW = AW - FS;
    localparam logic [AW-1:0] HALF = {{(AW - FS){1'b0}}, 1'b1, {(FS - 1){1'b0}}};
    localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

    logic [AW-1:0]               rsum  [qvr_pkg::NUM_AXES];
    logic [RW-1:0]               rnd   [qvr_pkg::NUM_AXES];
    logic [RW-VEC_WIDTH:0]       top   [qvr_pkg::NUM_AXES];
    logic signed [VEC_WIDTH-1:0] clip  [qvr_pkg::NUM_AXES];
    logic [qvr_pkg::NUM_AXES-1:0] ovf;

    logic signed [VEC_WIDTH-1:0] world_reg [qvr_pkg::NUM_AXES];
    logic                        sat_reg;

    // round half up, then floor by 2^FS
    always_comb
    begin
        for (int i = 0; i < qvr_pkg::NUM_AXES; i++)
        begin
            rsum[i] = acc[i] + HALF;
            rnd[i]  = rsum[i][AW-1:FS];
            top[i]  = rnd[i][RW-1:VEC_WIDTH-1];
            ovf[i]  = !((&top[i]) || !(|top[i]));
            if (!ovf[i])
            begin
                clip[i] = rnd[i][VEC_WIDTH-1:0];
            end
            else if (rnd[i][RW-1])
            begin
                clip[i] = VMIN;
            end
            else
            begin
                clip[i] = VMAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            world_reg <= clip;
            sat_reg   <= |ovf;
        end
    end

    assign world     = world_reg;
    assign saturated = sat_reg;

endmodule

[sv/quaternion_vector_rotation.sv]
// Quaternion vector rotation top level: body-frame vector to world frame.
// Takes one item per clock and returns one result per item. The path is a
// fixed pipeline: quaternion products, matrix sums, three row lanes (split
// partial products, column sums, row sum) and a merge stage that rounds to
// nearest (ties up), saturates and holds the output register. The quaternion
// is not normalized, so results scale by |q|^2; saturated is set when any
// component was clipped. While an output item waits on ready the whole
// pipeline holds, and input ready drops with it.
module quaternion_vector_rotation #(
    parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    qvr_in_if.sink    in_item,
    qvr_out_if.source out_item
);
    localparam int MW  = 2 * QUAT_WIDTH + 2;
    localparam int AW  = 2 * QUAT_WIDTH + VEC_WIDTH + 4;
    localparam int LAT = 6;
    localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

    logic                        en;
    logic [LAT-1:0]              vld_reg;
    logic [LAT-1:0]              vld_next;
    logic signed [VEC_WIDTH-1:0] body  [qvr_pkg::NUM_AXES];
    logic signed [MW-1:0]        mat   [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES];
    logic signed [VEC_WIDTH-1:0] vec   [qvr_pkg::NUM_AXES];
    logic signed [AW-1:0]        acc   [qvr_pkg::NUM_AXES];
    logic signed [VEC_WIDTH-1:0] world [qvr_pkg::NUM_AXES];
    logic                        sat;

    assign en = !vld_reg[LAT-1] || out_item.ready;
    assign in_item.ready = en;

    assign body[0] = in_item.body_x;
    assign body[1] = in_item.body_y;
    assign body[2] = in_item.body_z;

    always_comb
    begin
        vld_next = vld_reg;
        if (en)
        begin
            vld_next = {vld_reg[LAT-2:0], in_item.valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    qvr_matrix #(
        .QUAT_WIDTH (QUAT_WIDTH),
        .VEC_WIDTH  (VEC_WIDTH)
    ) u_matrix (
        .clk    (clk),
        .en     (en),
        .quat_x (in_item.quat_x),
        .quat_y (in_item.quat_y),
        .quat_z (in_item.quat_z),
        .quat_w (in_item.quat_w),
        .body   (body),
        .mat    (mat),
        .vec    (vec)
    );

    for (genvar i = 0; i < qvr_pkg::NUM_AXES; i++)
    begin : g_lane
        qvr_lane #(
            .QUAT_WIDTH (QUAT_WIDTH),
            .VEC_WIDTH  (VEC_WIDTH)
        ) u_lane (
            .clk (clk),
            .en  (en),
            .row (mat[i]),
            .vec (vec),
            .acc (acc[i])
        );
    end

    qvr_merge #(
        .QUAT_WIDTH (QUAT_WIDTH),
        .VEC_WIDTH  (VEC_WIDTH)
    ) u_merge (
        .clk       (clk),
        .en        (en),
        .acc       (acc),
        .world     (world),
        .saturated (sat)
    );

    assign out_item.valid     = vld_reg[LAT-1];
    assign out_item.world_x   = world[0];
    assign out_item.world_y   = world[1];
    assign out_item.world_z   = world[2];
    assign out_item.saturated = sat;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_item.valid && in_item.ready |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && !out_item.ready |-> !in_item.ready)
        else $error("input accepted while output stalled");

    a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_item.valid |-> in_item.ready)
        else $error("input held off with empty output stage");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && out_item.saturated |->
            (out_item.world_x == VMAX || out_item.world_x == VMIN ||
             out_item.world_y == VMAX || out_item.world_y == VMIN ||
             out_item.world_z == VMAX || out_item.world_z == VMIN))
        else $error("saturated flag without a clipped component");

endmodule

[tb/quaternion_vector_rotation_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the quaternion vector rotation block.

typedef logic signed [qvr_pkg::QUAT_WIDTH_DEF-1:0] quat_t;
typedef logic signed [qvr_pkg::VEC_WIDTH_DEF-1:0]  vec_t;
typedef logic signed [95:0]                         wide_t;

typedef struct packed {
    quat_t x;
    quat_t y;
    quat_t z;
    quat_t w;
    vec_t  bx;
    vec_t  by;
    vec_t  bz;
} rot_in_t;

typedef struct packed {
    vec_t wx;
    vec_t wy;
    vec_t wz;
    logic sat;
} rot_out_t;

class rotation_scoreboard;
    localparam int VW   = $bits(vec_t);
    localparam int FRAC = 2 * ($bits(quat_t) - 2);

    rot_out_t expected_worlds[$];
    int checked;
    int clipped;
    int mismatches;
    int stray;

    function rot_out_t rotate_vector(rot_in_t it);
        wide_t q[4];
        wide_t v[3];
        wide_t p[4][4];
        wide_t m[3][3];
        wide_t acc;
        wide_t r;
        wide_t hi = (wide_t'(1) <<< (VW - 1)) - 1;
        wide_t lo = -hi - 1;
        vec_t  w[3];
        logic  sat = 1'b0;
        rot_out_t res;
        q[0] = it.w;
        q[1] = it.x;
        q[2] = it.y;
        q[3] = it.z;
        v[0] = it.bx;
        v[1] = it.by;
        v[2] = it.bz;
        foreach (p[a, b])
            p[a][b] = q[a] * q[b];
        m[0][0] = p[0][0] + p[1][1] - p[2][2] - p[3][3];
        m[0][1] = 2 * (p[1][2] - p[0][3]);
        m[0][2] = 2 * (p[0][2] + p[1][3]);
        m[1][0] = 2 * (p[0][3] + p[1][2]);
        m[1][1] = p[0][0] - p[1][1] + p[2][2] - p[3][3];
        m[1][2] = 2 * (p[2][3] - p[0][1]);
        m[2][0] = 2 * (p[1][3] - p[0][2]);
        m[2][1] = 2 * (p[0][1] + p[2][3]);
        m[2][2] = p[0][0] - p[1][1] - p[2][2] + p[3][3];
        for (int i = 0; i < qvr_pkg::NUM_AXES; i++)
        begin
            acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
            // round half up, then drop the fraction bits
            r = (acc + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
            if (r > hi)
            begin
                r   = hi;
                sat = 1'b1;
            end
            else if (r < lo)
            begin
                r   = lo;
                sat = 1'b1;
            end
            w[i] = r[VW-1:0];
        end
        res.wx  = w[0];
        res.wy  = w[1];
        res.wz  = w[2];
        res.sat = sat;
        return res;
    endfunction

    function void note_input(rot_in_t it);
        expected_worlds.push_back(rotate_vector(it));
    endfunction

    function void check_result(rot_out_t got);
        rot_out_t want;
        vec_t     w_exp[3];
        vec_t     w_got[3];
        bit       bad;
        if (expected_worlds.size() == 0)
        begin
            stray++;
            if (stray + mismatches <= 10)
                $display("ERROR: result (%0d, %0d, %0d, sat %0b) with no pending item",
                         got.wx, got.wy, got.wz, got.sat);
            return;
        end
        want = expected_worlds.pop_front();
        checked++;
        if (want.sat)
            clipped++;
        w_exp = '{want.wx, want.wy, want.wz};
        w_got = '{got.wx, got.wy, got.wz};
        bad   = (got.sat !== want.sat);
        foreach (w_exp[i])
            if (w_got[i] !== w_exp[i])
                bad = 1'b1;
        if (bad)
        begin
            mismatches++;
            if (stray + mismatches <= 10)
                $display({"ERROR: result %0d expected (%0d, %0d, %0d, sat %0b)",
                          " got (%0d, %0d, %0d, sat %0b)"},
                         checked, want.wx, want.wy, want.wz, want.sat,
                         got.wx, got.wy, got.wz, got.sat);
        end
    endfunction

    function int failures();
        return mismatches + stray;
    endfunction
endclass

module quaternion_vector_rotation_tb;

    localparam int    QW       = qvr_pkg::QUAT_WIDTH_DEF;
    localparam int    VW       = qvr_pkg::VEC_WIDTH_DEF;
    localparam int    QONE     = 1 << (QW - 2);
    localparam int    C45      = 11585;        // cos(45 deg) in Q2.14
    localparam int    RND_ITEMS = 200;         // per pacing phase
    localparam quat_t QMAX     = {1'b0, {(QW-1){1'b1}}};
    localparam quat_t QMIN     = {1'b1, {(QW-1){1'b0}}};
    localparam vec_t  VMAX     = {1'b0, {(VW-1){1'b1}}};
    localparam vec_t  VMIN     = {1'b1, {(VW-1){1'b0}}};
    localparam vec_t  V_HALF   = vec_t'(1) <<< 27;
    localparam vec_t  V_QTR    = vec_t'(1) <<< (VW - 3);

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   sent;
    int   directed_cnt;
    rot_out_t seen;
    rotation_scoreboard sb;

    qvr_in_if  #(.QUAT_WIDTH(QW), .VEC_WIDTH(VW)) in_if ();
    qvr_out_if #(.VEC_WIDTH(VW))                  out_if ();

    quaternion_vector_rotation #(
        .QUAT_WIDTH (QW),
        .VEC_WIDTH  (VW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_if),
        .out_item (out_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic rot_in_t mk_rot(quat_t qx, quat_t qy, quat_t qz, quat_t qw,
                                       vec_t bx, vec_t by, vec_t bz);
        rot_in_t it;
        it = '{qx, qy, qz, qw, bx, by, bz};
        return it;
    endfunction

    function automatic vec_t rand_vec(int shift);
        vec_t t;
        t = vec_t'({$urandom, $urandom});
        return t >>> shift;
    endfunction

    function automatic quat_t pick_quat_extreme();
        case ($urandom_range(3))
            0:       return QMAX;
            1:       return QMIN;
            2:       return '0;
            default: return quat_t'($urandom);
        endcase
    endfunction

    function automatic vec_t pick_vec_extreme();
        case ($urandom_range(3))
            0:       return VMAX;
            1:       return VMIN;
            2:       return '0;
            default: return rand_vec(0);
        endcase
    endfunction

    function automatic rot_in_t random_rotation();
        rot_in_t it;
        real     a[4];
        real     nrm;
        int      mode;
        mode = $urandom_range(99);
        if (mode < 45)
        begin
            // near-unit quaternion, vector of random magnitude
            nrm = 0.0;
            foreach (a[i])
            begin
                a[i] = real'(int'($urandom_range(65535)) - 32768);
                nrm += a[i] * a[i];
            end
            nrm = $sqrt(nrm);
            if (nrm < 1.0)
            begin
                a   = '{0.0, 0.0, 0.0, 1.0};
                nrm = 1.0;
            end
            it.x  = quat_t'(int'(a[0] / nrm * QONE));
            it.y  = quat_t'(int'(a[1] / nrm * QONE));
            it.z  = quat_t'(int'(a[2] / nrm * QONE));
            it.w  = quat_t'(int'(a[3] / nrm * QONE));
            it.bx = rand_vec($urandom_range(0, 20));
            it.by = rand_vec($urandom_range(0, 20));
            it.bz = rand_vec($urandom_range(0, 20));
        end
        else if (mode < 75)
        begin
            it.x  = quat_t'($urandom);
            it.y  = quat_t'($urandom);
            it.z  = quat_t'($urandom);
            it.w  = quat_t'($urandom);
            it.bx = rand_vec($urandom_range(6, 24));
            it.by = rand_vec($urandom_range(6, 24));
            it.bz = rand_vec($urandom_range(6, 24));
        end
        else if (mode < 90)
        begin
            it.x  = quat_t'($urandom);
            it.y  = quat_t'($urandom);
            it.z  = quat_t'($urandom);
            it.w  = quat_t'($urandom);
            it.bx = rand_vec(0);
            it.by = rand_vec(0);
            it.bz = rand_vec(0);
        end
        else
        begin
            it.x  = pick_quat_extreme();
            it.y  = pick_quat_extreme();
            it.z  = pick_quat_extreme();
            it.w  = pick_quat_extreme();
            it.bx = pick_vec_extreme();
            it.by = pick_vec_extreme();
            it.bz = pick_vec_extreme();
        end
        return it;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_rotation(input rot_in_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid  <= 1'b1;
        in_if.quat_x <= it.x;
        in_if.quat_y <= it.y;
        in_if.quat_z <= it.z;
        in_if.quat_w <= it.w;
        in_if.body_x <= it.bx;
        in_if.body_y <= it.by;
        in_if.body_z <= it.bz;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_input(it);
        sent++;
        @(negedge clk);
    endtask

    task automatic run_directed();
        // identity, zero and full-scale vectors
        send_rotation(mk_rot(0, 0, 0, QONE, 0, 0, 0));
        send_rotation(mk_rot(0, 0, 0, QONE, VMAX, VMIN, 1));
        send_rotation(mk_rot(0, 0, 0, QONE, -1, 32'sh1234_5678, -65536));
        // quarter turns about z and y, half turn about x
        send_rotation(mk_rot(0, 0, C45, C45, 65536, 0, 0));
        send_rotation(mk_rot(0, C45, 0, C45, 0, 0, 65536));
        send_rotation(mk_rot(QONE, 0, 0, 0, 65536, 131072, -196608));
        // tiny scale: rounding ties go up
        send_rotation(mk_rot(0, 0, 0, 1, V_HALF, -V_HALF, V_HALF - 1));
        send_rotation(mk_rot(0, 0, 0, 1, -V_HALF - 1, 3 * V_HALF, -3 * V_HALF));
        // extremes everywhere
        send_rotation(mk_rot(QMAX, QMAX, QMAX, QMAX, VMAX, VMAX, VMAX));
        send_rotation(mk_rot(QMIN, QMIN, QMIN, QMIN, VMIN, VMIN, VMIN));
        send_rotation(mk_rot(QMIN, QMIN, QMIN, QMIN, VMAX, VMIN, 0));
        send_rotation(mk_rot(QMAX, QMIN, QMAX, QMIN, VMAX, VMIN, VMAX));
        // w = -2: scale by 4, saturation right at the boundary
        send_rotation(mk_rot(0, 0, 0, QMIN, VMAX, VMIN, V_QTR));
        send_rotation(mk_rot(0, 0, 0, QMIN, -V_QTR, V_QTR - 1, -V_QTR - 1));
        // non-unit quaternions
        send_rotation(mk_rot(0, 0, 0, QMAX, 65536, -65536, 12345));
        send_rotation(mk_rot(QONE, QONE, QONE, QONE, 65536, -65536, 1));
        send_rotation(mk_rot(QMAX, 0, 0, 0, 1, 1, 1));
        send_rotation(mk_rot(0, 0, 0, 0, VMAX, VMIN, VMAX));
        send_rotation(mk_rot(1, -1, 1, -1, VMAX, VMIN, -1));
    endtask

    initial
    begin
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            @(posedge clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
            begin
                seen.wx  = out_if.world_x;
                seen.wy  = out_if.world_y;
                seen.wz  = out_if.world_z;
                seen.sat = out_if.saturated;
                sb.check_result(seen);
            end
        end
    end

    initial
    begin
        sb           = new();
        sent         = 0;
        src_idle_pct = 20;
        snk_idle_pct = 53;
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.quat_x = '0;
        in_if.quat_y = '0;
        in_if.quat_z = '0;
        in_if.quat_w = '0;
        in_if.body_x = '0;
        in_if.body_y = '0;
        in_if.body_z = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        directed_cnt = sent;
        repeat (RND_ITEMS) send_rotation(random_rotation());
        src_idle_pct = 53;
        snk_idle_pct = 20;
        repeat (RND_ITEMS) send_rotation(random_rotation());
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (RND_ITEMS) send_rotation(random_rotation());
        in_if.valid <= 1'b0;

        while (sb.expected_worlds.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        $display("Rotated %0d items (%0d directed), %0d results checked, %0d saturated,",
                 sent, directed_cnt, sb.checked, sb.clipped);
        $display("over three pacing phases; %0d mismatches, %0d unexpected results",
                 sb.mismatches, sb.stray);
        if (sb.failures() == 0 && sb.expected_worlds.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
